@@ rtl/lkvc_pkg.sv @@
// Package for the LRU key/value cache: sizes, register index, payload structs
// and the link structs that run along the row of storage cells.
// No dependencies.
`default_nettype none

package lkvc_pkg;

    // Number of storage cells in the row (1 to 256)
    localparam int ENTRIES = 16;
    // Width of a cell index
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Field widths
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    // APB register map: one 32-bit word per register
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'b0;

    localparam logic [CAP_W-1:0] CAPACITY_RST = 5'd16;

    // Operation codes
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    // Read value returned by a get that misses
    localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

    // Request item
    typedef struct packed {
        logic                     func;
        logic signed [KEY_W-1:0]  key;
        logic signed [VAL_W-1:0]  value;
    } lkvc_req_t;

    // Result item
    typedef struct packed {
        logic                     hit;
        logic signed [VAL_W-1:0]  read_value;
        logic                     evicted;
        logic signed [KEY_W-1:0]  evicted_key;
    } lkvc_rsp_t;

    // Entry content handed from a cell to the next one down the row
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             valid;
    } lkvc_entry_t;

    // Lookup results gathered along the row
    typedef struct packed {
        logic             match;
        logic [VAL_W-1:0] hit_value;
        logic [KEY_W-1:0] tail_key;
    } lkvc_scan_t;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic [KEY_W-1:0] req_key;
        logic             do_hit;
        logic             do_ins;
        logic             evict;
    } lkvc_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/lru_key_value_cache_unit.sv @@
// LRU key/value cache unit: request register, row of lkvc_cell storage cells,
// result register and the APB capacity register. Depends on lkvc_pkg, lkvc_cell.
`default_nettype none

// Fully associative key/value cache with least-recently-used replacement,
// held in a row of ENTRIES cells kept in recency order (cell 0 most recent).
// Each item is a get or a put and yields exactly one result item. An item is
// registered on acceptance and resolved once the result register is free,
// when all cells compare the key at once and the row shifts by one position;
// the result item is then registered, and one item per cycle is sustained
// while the result side keeps m_ready high. The capacity register (APB
// offset 0) limits how many entries are used before the least recent one is
// evicted; 0 acts as 1 and values above ENTRIES act as ENTRIES. Write it only
// while no item is in flight. The store is empty after reset.
module lru_key_value_cache_unit (
    input  wire                              aclk,
    input  wire                              aresetn,
    // Request channel
    input  wire                              s_valid,
    output logic                             s_ready,
    input  lkvc_pkg::lkvc_req_t              s_data,
    // Result channel
    output logic                             m_valid,
    input  wire                              m_ready,
    output lkvc_pkg::lkvc_rsp_t              m_data,
    // APB configuration port
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [lkvc_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire [lkvc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lkvc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam int N = lkvc_pkg::ENTRIES;

    logic [lkvc_pkg::CAP_W-1:0]    capacity_reg;
    logic [lkvc_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          cfg_write;

    logic                          req_valid_reg;
    logic                          req_valid_next;
    lkvc_pkg::lkvc_req_t           req_reg;

    logic                          m_valid_reg;
    logic                          m_valid_next;
    lkvc_pkg::lkvc_rsp_t           m_data_reg;
    lkvc_pkg::lkvc_rsp_t           m_data_next;

    logic                          out_free;
    logic                          process;
    logic                          hit;
    logic                          evict;
    logic [lkvc_pkg::IDX_W-1:0]    cap_idx;
    logic [N-1:0]                  valid_vec;
    logic [lkvc_pkg::VAL_W-1:0]    head_value;

    lkvc_pkg::lkvc_ctrl_t          ctrl;
    lkvc_pkg::lkvc_entry_t         entry_chain [N+1];
    lkvc_pkg::lkvc_scan_t          scan_chain  [N+1];

    // APB register access
    assign pready    = 1'b1;
    assign reg_idx   = paddr[2 +: lkvc_pkg::REG_IDX_W];
    assign cfg_write = psel && penable && pwrite && (reg_idx == lkvc_pkg::REG_CAPACITY);
    assign prdata    = (reg_idx == lkvc_pkg::REG_CAPACITY) ?
                       lkvc_pkg::APB_DATA_W'(capacity_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= lkvc_pkg::CAPACITY_RST;
        end else if (cfg_write) begin
            capacity_reg <= pwdata[lkvc_pkg::CAP_W-1:0];
        end
    end

    // Last cell in use before eviction starts
    always_comb begin
        if (int'(capacity_reg) >= N) begin
            cap_idx = lkvc_pkg::IDX_W'(N - 1);
        end else if (capacity_reg == '0) begin
            cap_idx = '0;
        end else begin
            cap_idx = lkvc_pkg::IDX_W'(capacity_reg) - lkvc_pkg::IDX_W'(1);
        end
    end

    // Handshake: the request register refills while its item is resolved
    assign out_free = !m_valid_reg || m_ready;
    assign process  = req_valid_reg && out_free;
    assign s_ready  = !req_valid_reg || out_free;

    always_comb begin
        req_valid_next = req_valid_reg;
        if (s_valid && s_ready) begin
            req_valid_next = 1'b1;
        end else if (process) begin
            req_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else begin
            req_valid_reg <= req_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
    end

    // Command for the cell row
    assign hit   = scan_chain[N].match;
    assign evict = (req_reg.func == lkvc_pkg::FUNC_PUT) && !hit && valid_vec[cap_idx];

    assign ctrl.req_key = req_reg.key;
    assign ctrl.do_hit  = process && hit;
    assign ctrl.do_ins  = process && !hit && (req_reg.func == lkvc_pkg::FUNC_PUT);
    assign ctrl.evict   = evict;

    // Head of the row: the entry that becomes most recent
    assign head_value = (req_reg.func == lkvc_pkg::FUNC_PUT) ?
                        req_reg.value : scan_chain[N].hit_value;

    assign entry_chain[0].key   = req_reg.key;
    assign entry_chain[0].value = head_value;
    assign entry_chain[0].valid = 1'b1;

    assign scan_chain[0].match     = 1'b0;
    assign scan_chain[0].hit_value = '0;
    assign scan_chain[0].tail_key  = '0;

    // Row of cells
    for (genvar i = 0; i < N; i++) begin : g_cell
        logic valid_below;

        if (i == N - 1) begin : g_last
            assign valid_below = 1'b0;
        end else begin : g_mid
            assign valid_below = entry_chain[i+2].valid;
        end

        lkvc_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .entry_in    (entry_chain[i]),
            .scan_in     (scan_chain[i]),
            .valid_below (valid_below),
            .entry_out   (entry_chain[i+1]),
            .scan_out    (scan_chain[i+1])
        );

        assign valid_vec[i] = entry_chain[i+1].valid;
    end

    // Result item
    always_comb begin
        m_data_next.hit         = hit;
        m_data_next.evicted     = evict;
        m_data_next.evicted_key = evict ? scan_chain[N].tail_key : '0;
        if (req_reg.func == lkvc_pkg::FUNC_PUT) begin
            m_data_next.read_value = '0;
        end else if (hit) begin
            m_data_next.read_value = scan_chain[N].hit_value;
        end else begin
            m_data_next.read_value = lkvc_pkg::MISS_VALUE;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (process) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (process) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Occupied cells always form one run starting at cell 0
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot({1'b0, valid_vec} + (N+1)'(1)))
        else $error("valid cells not contiguous from the head");

    // A get that misses leaves the store untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        (process && !hit && req_reg.func == lkvc_pkg::FUNC_GET) |=> $stable(valid_vec))
        else $error("get miss changed the store");

    // An eviction keeps the occupancy unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        (process && evict) |=> ($countones(valid_vec) == $past($countones(valid_vec))))
        else $error("eviction changed the occupancy");

    // A hit moves the key to the head of the row
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.do_hit |=> (entry_chain[1].key == $past(req_reg.key)))
        else $error("hit entry not promoted to the head");

endmodule

`default_nettype wire

@@ rtl/lkvc_cell.sv @@
// One storage cell of the LRU row: holds a key, a value and a valid flag,
// compares against the broadcast key and takes its upstream neighbor's entry
// on a shift. Depends on lkvc_pkg.
`default_nettype none

module lkvc_cell (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  lkvc_pkg::lkvc_ctrl_t  ctrl,
    input  lkvc_pkg::lkvc_entry_t entry_in,
    input  lkvc_pkg::lkvc_scan_t  scan_in,
    input  wire                 valid_below,
    output lkvc_pkg::lkvc_entry_t entry_out,
    output lkvc_pkg::lkvc_scan_t  scan_out
);

    logic [lkvc_pkg::KEY_W-1:0] key_reg;
    logic [lkvc_pkg::VAL_W-1:0] value_reg;
    logic                       valid_reg;
    logic                       match;
    logic                       tail;
    logic                       shift;

    // Key compare and position flags
    assign match = valid_reg && (key_reg == ctrl.req_key);
    assign tail  = valid_reg && !valid_below;

    // Shift down on a hit above or at the matching cell; on an insert, the
    // valid run moves down by one (or stays put at the tail on an eviction)
    assign shift = (ctrl.do_hit && !scan_in.match) ||
                   (ctrl.do_ins && (ctrl.evict ? valid_reg : entry_in.valid));

    // Storage: valid is control, key and value are payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift) begin
            valid_reg <= entry_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift) begin
            key_reg   <= entry_in.key;
            value_reg <= entry_in.value;
        end
    end

    assign entry_out.key   = key_reg;
    assign entry_out.value = value_reg;
    assign entry_out.valid = valid_reg;

    // Gather lookup results toward the tail of the row
    assign scan_out.match     = scan_in.match || match;
    assign scan_out.hit_value = scan_in.hit_value |
                                (match ? value_reg : '0);
    assign scan_out.tail_key  = scan_in.tail_key |
                                (tail ? key_reg : '0);

endmodule

`default_nettype wire
